FILE: design/mpsp_pkg.sv
// Package for the multi-pin soft PWM scheduler: shared widths, codes and beat types.
// No dependencies; every other design file imports it.
`default_nettype none
package mpsp_pkg;

  localparam int unsigned PIN_COUNT = 24;
  localparam int unsigned PIN_W     = 5;
  localparam int unsigned FREQ_W    = 19;
  localparam int unsigned INFREQ_W  = 20;
  localparam int unsigned DUTY_W    = 7;
  localparam int unsigned DELAY_W   = 20;
  localparam int unsigned DIV_W     = 27;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [DUTY_W-1:0]  DUTY_MAX  = 7'd100;
  localparam logic [DELAY_W-1:0] MIN_DELAY = 20'd2;
  localparam logic [DELAY_W-1:0] MIN_PERIOD = 20'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ = 1'b1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_LEVEL = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [PIN_W-1:0]    pin_index;
    logic [INFREQ_W-1:0] freq_hz;
    logic [DUTY_W-1:0]   duty_percent;
    logic                level;
  } in_beat_t;

  typedef struct packed {
    logic [PIN_COUNT-1:0] pin_levels;
    logic [PIN_COUNT-1:0] soft_mask;
    logic [FREQ_W-1:0]    actual_freq_hz;
    logic                 timer_restart;
    logic [DELAY_W-1:0]   next_delay_us;
  } out_beat_t;

  typedef struct packed {
    logic capture;
    logic clamp;
    logic div_start;
    logic pct_mul;
    logic mul;
    logic apply;
    logic manual;
    logic tick_adv;
    logic tick_resync;
    logic tick_step;
    logic tick_next;
    logic finish;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic pin_ok;
    logic div_done;
    logic cur_tog;
    logic due;
    logic last_pin;
  } sts_t;

endpackage
`default_nettype wire

FILE: design/multi_pin_soft_pwm_scheduler.sv
// Multi-pin software PWM scheduler, top level.
// Input beats carry an op (start, stop, manual level, timer expiry) for a table
// of 24 pins; each accepted beat yields exactly one result beat with all pin
// levels, the soft mode mask, the applied frequency and any timer restart.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// The block holds one beat at a time: in_stall_o is high from acceptance until
// the result is written to the output register. A start makes one pass through
// the serial divider for the period, then a reciprocal multiply for the duty
// split; a timer expiry walks all 24 pins and replays each due edge.
// A finished result waits in the output register while out_stall_i is high;
// the next beat is accepted meanwhile and its result waits until the slot frees.
// min_freq_hz and max_freq_hz are written through cfg_we_i/cfg_idx_i/cfg_wdata_i,
// and the user must write them only while the block is idle; the block itself
// does not enforce this. Reset (rst_ni low, asynchronous) puts every pin in
// manual mode, low, and clears virtual time; the limits return to 1 and 10000.
// Depends on mpsp_pkg, mpsp_ctrl, mpsp_dpath and mpsp_div.
`default_nettype none
module multi_pin_soft_pwm_scheduler #(
  parameter int unsigned TICK_HZ = 1000000
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mpsp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mpsp_pkg::FREQ_W-1:0]    cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire mpsp_pkg::in_beat_t             in_beat_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output mpsp_pkg::out_beat_t                 out_beat_o
);
  import mpsp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mpsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mpsp_dpath #(
    .TICK_HZ (TICK_HZ)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_beat_i   (in_beat_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_beat_o  (out_beat_o)
  );

endmodule
`default_nettype wire

FILE: design/mpsp_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on mpsp_pkg for operand widths.
`default_nettype none
module mpsp_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [mpsp_pkg::DIV_W-1:0]  dividend_i,
  input  wire logic [mpsp_pkg::FREQ_W-1:0] divisor_i,
  output logic                             done_o,
  output logic [mpsp_pkg::DIV_W-1:0]       quot_o
);
  import mpsp_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [DIV_W-1:0]   dvd_q, dvd_d;
  logic [FREQ_W-1:0]  rem_q, rem_d;
  logic [FREQ_W-1:0]  dsr_q, dsr_d;
  logic [FREQ_W:0]    trial;
  logic               ge;

  assign trial = {rem_q, dvd_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? FREQ_W'(trial - {1'b0, dsr_q}) : FREQ_W'(trial);
      dvd_d = {dvd_q[DIV_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule
`default_nettype wire

FILE: design/mpsp_dpath.sv
// Datapath: config registers, pin table, virtual time, tick walk and result register.
// Depends on mpsp_pkg and mpsp_div.
`default_nettype none
module mpsp_dpath #(
  parameter int unsigned TICK_HZ = 1000000
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mpsp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mpsp_pkg::FREQ_W-1:0]    cfg_wdata_i,
  input  wire mpsp_pkg::in_beat_t             in_beat_i,
  input  wire mpsp_pkg::cmd_t                 cmd_i,
  output mpsp_pkg::sts_t                      sts_o,
  output mpsp_pkg::out_beat_t                 out_beat_o
);
  import mpsp_pkg::*;

  localparam logic [DIV_W-1:0]   TICK_DVD = DIV_W'(TICK_HZ);
  localparam logic [DELAY_W-1:0] TICK_DLY = DELAY_W'(TICK_HZ);
  // divide by 100 as a quarter times ceil(2^30 / 25), shifted down by 30
  localparam logic [25:0]        RECIP_25 = 26'd42949673;

  in_beat_t             beat_q;
  logic [FREQ_W-1:0]    fmin_q, fmax_q;
  logic [FREQ_W-1:0]    freq_q;
  logic [DUTY_W-1:0]    duty_q;
  logic [DELAY_W-1:0]   period_q;
  logic [DIV_W-1:0]     prod_q;
  logic [DELAY_W-1:0]   hiv_q;
  logic                 restart_q;
  logic [DELAY_W-1:0]   delay_q;
  logic [PIN_COUNT-1:0] soft_q, tog_q, lvl_q;
  logic [DELAY_W-1:0]   hi_q  [PIN_COUNT];
  logic [DELAY_W-1:0]   lo_q  [PIN_COUNT];
  logic [TIME_W-1:0]    nxt_q [PIN_COUNT];
  logic [TIME_W-1:0]    now_q;
  logic [DELAY_W-1:0]   last_q;
  logic [PIN_W-1:0]     ptr_q;
  logic                 any_q;
  logic [DELAY_W-1:0]   mind_q;
  out_beat_t            out_q;

  logic [INFREQ_W-1:0]  f_in;
  logic [FREQ_W-1:0]    f_clamp;
  logic [DUTY_W-1:0]    d_clamp;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quot;
  logic [49:0]          pct_full;
  logic [DELAY_W-1:0]   per_raw, per_fix;
  logic [DELAY_W-1:0]   hi_new, lo_new;
  logic [PIN_W-1:0]     pidx;
  logic [DELAY_W:0]     per_sum;
  logic [TIME_W-1:0]    nxt_cur, late_lim;
  logic [DELAY_W-1:0]   delta;
  logic [DELAY_W-1:0]   tick_dly;
  logic                 pin_ok;

  assign pidx   = beat_q.pin_index;
  assign pin_ok = beat_q.pin_index < PIN_W'(PIN_COUNT);

  always_comb begin
    f_in = beat_q.freq_hz;
    if (f_in < {1'b0, fmin_q}) begin
      f_clamp = fmin_q;
    end else if (f_in > {1'b0, fmax_q}) begin
      f_clamp = fmax_q;
    end else begin
      f_clamp = f_in[FREQ_W-1:0];
    end
    if (f_clamp == '0) begin
      f_clamp = FREQ_W'(1);
    end
    d_clamp = (beat_q.duty_percent > DUTY_MAX) ? DUTY_MAX : beat_q.duty_percent;
  end

  mpsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (TICK_DVD),
    .divisor_i  (freq_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign pct_full = 50'(prod_q[DIV_W-1:2]) * 50'(RECIP_25);
  assign per_raw  = div_quot[DELAY_W-1:0];
  assign per_fix  = (per_raw < MIN_PERIOD) ? MIN_PERIOD : per_raw;
  assign hi_new   = hiv_q;
  assign lo_new   = period_q - hi_new;
  assign nxt_cur  = nxt_q[ptr_q];
  assign per_sum  = {1'b0, hi_q[ptr_q]} + {1'b0, lo_q[ptr_q]};
  assign late_lim = nxt_cur + TIME_W'(per_sum);
  assign delta    = DELAY_W'(nxt_cur - now_q);

  always_comb begin
    tick_dly = any_q ? mind_q : TICK_DLY;
    if (tick_dly < MIN_DELAY) begin
      tick_dly = MIN_DELAY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmin_q    <= FREQ_W'(1);
      fmax_q    <= FREQ_W'(10000);
      soft_q    <= '0;
      tog_q     <= '0;
      lvl_q     <= '0;
      now_q     <= '0;
      last_q    <= '0;
      ptr_q     <= '0;
      any_q     <= 1'b0;
      restart_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MIN_FREQ) begin
          fmin_q <= cfg_wdata_i;
        end else begin
          fmax_q <= cfg_wdata_i;
        end
      end
      if (cmd_i.capture) begin
        restart_q <= 1'b0;
      end
      if (cmd_i.apply) begin
        soft_q[pidx] <= 1'b1;
        if (duty_q == '0 || hi_new == '0) begin
          tog_q[pidx] <= 1'b0;
          lvl_q[pidx] <= 1'b0;
        end else if (duty_q == DUTY_MAX || lo_new == '0) begin
          tog_q[pidx] <= 1'b0;
          lvl_q[pidx] <= 1'b1;
        end else begin
          tog_q[pidx] <= 1'b1;
          lvl_q[pidx] <= 1'b1;
          if (tog_q == '0) begin
            last_q    <= MIN_DELAY;
            restart_q <= 1'b1;
          end
        end
      end
      if (cmd_i.manual) begin
        if (soft_q[pidx]) begin
          soft_q[pidx] <= 1'b0;
          tog_q[pidx]  <= 1'b0;
        end
        if (beat_q.op == OP_LEVEL) begin
          lvl_q[pidx] <= beat_q.level;
        end else if (soft_q[pidx]) begin
          lvl_q[pidx] <= 1'b0;
        end
      end
      if (cmd_i.tick_adv) begin
        now_q     <= now_q + TIME_W'(last_q);
        ptr_q     <= '0;
        any_q     <= 1'b0;
        restart_q <= 1'b1;
      end
      if (cmd_i.tick_step) begin
        lvl_q[ptr_q] <= ~lvl_q[ptr_q];
      end
      if (cmd_i.tick_next) begin
        if (tog_q[ptr_q] && (!any_q || delta < mind_q)) begin
          any_q <= 1'b1;
        end
        ptr_q <= ptr_q + PIN_W'(1);
      end
      if (cmd_i.finish && beat_q.op == OP_TICK) begin
        last_q <= tick_dly;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      beat_q <= in_beat_i;
      freq_q <= '0;
    end
    if (cmd_i.clamp) begin
      freq_q <= f_clamp;
      duty_q <= d_clamp;
    end
    if (cmd_i.mul) begin
      period_q <= per_fix;
      prod_q   <= DIV_W'(per_fix) * DIV_W'(duty_q);
    end
    if (cmd_i.pct_mul) begin
      hiv_q <= pct_full[49:30];
    end
    if (cmd_i.apply) begin
      hi_q[pidx] <= hi_new;
      lo_q[pidx] <= lo_new;
      if (duty_q != '0 && hi_new != '0 && duty_q != DUTY_MAX && lo_new != '0) begin
        nxt_q[pidx] <= now_q + TIME_W'(hi_new);
      end
    end
    if (cmd_i.tick_resync && tog_q[ptr_q] && now_q > late_lim) begin
      nxt_q[ptr_q] <= now_q;
    end
    if (cmd_i.tick_step) begin
      nxt_q[ptr_q] <= nxt_cur + TIME_W'(lvl_q[ptr_q] ? lo_q[ptr_q] : hi_q[ptr_q]);
    end
    if (cmd_i.tick_next && tog_q[ptr_q] && (!any_q || delta < mind_q)) begin
      mind_q <= delta;
    end
    if (cmd_i.finish) begin
      out_q.pin_levels     <= lvl_q;
      out_q.soft_mask      <= soft_q;
      out_q.actual_freq_hz <= freq_q;
      if (beat_q.op == OP_TICK) begin
        out_q.timer_restart <= 1'b1;
        out_q.next_delay_us <= tick_dly;
      end else begin
        out_q.timer_restart <= restart_q;
        out_q.next_delay_us <= restart_q ? MIN_DELAY : '0;
      end
    end
  end

  assign sts_o.op       = beat_q.op;
  assign sts_o.pin_ok   = pin_ok;
  assign sts_o.div_done = div_done;
  assign sts_o.cur_tog  = tog_q[ptr_q];
  assign sts_o.due      = nxt_cur <= now_q;
  assign sts_o.last_pin = ptr_q == PIN_W'(PIN_COUNT - 1);
  assign out_beat_o     = out_q;

endmodule
`default_nettype wire

FILE: design/mpsp_ctrl.sv
// Controller state machine: sequences start, stop, level and tick beats and the result slot.
// Depends on mpsp_pkg for command and status types.
`default_nettype none
module mpsp_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  input  wire mpsp_pkg::sts_t sts_i,
  output mpsp_pkg::cmd_t      cmd_o
);
  import mpsp_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_CLAMP  = 4'd2;
  localparam logic [3:0] S_D1S    = 4'd3;
  localparam logic [3:0] S_D1W    = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_SCALE  = 4'd6;
  localparam logic [3:0] S_APPLY  = 4'd7;
  localparam logic [3:0] S_TADV   = 4'd8;
  localparam logic [3:0] S_TCHK   = 4'd9;
  localparam logic [3:0] S_TSTEP  = 4'd10;
  localparam logic [3:0] S_TNEXT  = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  cmd_t       cmd;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd         = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.op == OP_TICK) begin
          state_d = S_TADV;
        end else if (!sts_i.pin_ok) begin
          state_d = S_FIN;
        end else if (sts_i.op == OP_START) begin
          state_d = S_CLAMP;
        end else begin
          cmd.manual = 1'b1;
          state_d    = S_FIN;
        end
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_d   = S_D1S;
      end
      S_D1S: begin
        cmd.div_start = 1'b1;
        state_d       = S_D1W;
      end
      S_D1W: begin
        if (sts_i.div_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_d = S_SCALE;
      end
      S_SCALE: begin
        cmd.pct_mul = 1'b1;
        state_d     = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_d   = S_FIN;
      end
      S_TADV: begin
        cmd.tick_adv = 1'b1;
        state_d      = S_TCHK;
      end
      S_TCHK: begin
        cmd.tick_resync = 1'b1;
        state_d         = S_TSTEP;
      end
      S_TSTEP: begin
        if (sts_i.cur_tog && sts_i.due) begin
          cmd.tick_step = 1'b1;
        end else begin
          state_d = S_TNEXT;
        end
      end
      S_TNEXT: begin
        cmd.tick_next = 1'b1;
        state_d       = sts_i.last_pin ? S_FIN : S_TCHK;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.finish  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_fin_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a waiting beat");
  a_capture_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> state_q == S_DECODE)
    else $error("captured beat not decoded");
  a_div_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_D1W && sts_i.div_done) |=> state_q == S_MUL)
    else $error("period division result missed");
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> (state_q == S_IDLE && out_valid_o))
    else $error("finish did not present a result");
`endif

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Testbench for the multi-pin soft PWM scheduler: directed and random beats of
// every op, checked field by field against an in-bench scheduler predictor.
// Depends on mpsp_pkg and multi_pin_soft_pwm_scheduler.
`default_nettype none
module tb;
  import mpsp_pkg::*;

  localparam int unsigned NPINS = 24;
  localparam int unsigned TICKS_PER_S = 1000000;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned IN_BITS = $bits(in_beat_t);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_MIN_FREQ;
  logic [FREQ_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_beat_t in_beat_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_beat_t out_beat_o;

  multi_pin_soft_pwm_scheduler DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .in_beat_i(in_beat_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_beat_o(out_beat_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [FREQ_W-1:0] lim_min, lim_max;
  logic [NPINS-1:0] soft_q, tog_q, lvl_q;
  logic [31:0] hi_q [NPINS];
  logic [31:0] lo_q [NPINS];
  logic [63:0] edge_q [NPINS];
  logic [63:0] now_q;
  logic [31:0] last_dly_q;

  out_beat_t results_due [$];
  int errors = 0;
  int beats_sent = 0;
  int beats_seen = 0;
  int idle_cycles = 0;
  bit rand_out_stall = 1'b0;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [31:0] count_tog();
    logic [31:0] n;
    n = 0;
    for (int i = 0; i < NPINS; i++) n += tog_q[i];
    return n;
  endfunction

  function automatic out_beat_t pwm_predict(in_beat_t b);
    out_beat_t r;
    logic [31:0] f, d, per, hi, lo, mind, delta;
    logic [63:0] p;
    logic any, kick;
    int unsigned k;
    r = '0;
    k = b.pin_index;
    if (b.op == OP_TICK) begin
      now_q += last_dly_q;
      any = 1'b0;
      mind = 0;
      for (int i = 0; i < NPINS; i++) begin
        if (!tog_q[i]) continue;
        p = 64'(hi_q[i]) + 64'(lo_q[i]);
        if (now_q > edge_q[i] + p) edge_q[i] = now_q;
        while (edge_q[i] <= now_q) begin
          if (lvl_q[i]) begin
            lvl_q[i] = 1'b0;
            edge_q[i] += lo_q[i];
          end else begin
            lvl_q[i] = 1'b1;
            edge_q[i] += hi_q[i];
          end
        end
        delta = 32'(edge_q[i] - now_q);
        if (!any || delta < mind) begin
          any = 1'b1;
          mind = delta;
        end
      end
      if (!any) mind = TICKS_PER_S;
      if (mind < 2) mind = 2;
      last_dly_q = mind;
      r.timer_restart = 1'b1;
      r.next_delay_us = mind[DELAY_W-1:0];
    end else if (k < NPINS) begin
      if (b.op == OP_START) begin
        kick = (count_tog() == 0);
        f = b.freq_hz;
        if (f < lim_min) f = lim_min;
        else if (f > lim_max) f = lim_max;
        if (f == 0) f = 1;
        d = (b.duty_percent > 100) ? 100 : b.duty_percent;
        per = TICKS_PER_S / f;
        if (per < 2) per = 2;
        hi = (per * d) / 100;
        lo = per - hi;
        hi_q[k] = hi;
        lo_q[k] = lo;
        if (d == 0 || hi == 0) begin
          tog_q[k] = 1'b0;
          lvl_q[k] = 1'b0;
        end else if (d >= 100 || lo == 0) begin
          tog_q[k] = 1'b0;
          lvl_q[k] = 1'b1;
        end else begin
          tog_q[k] = 1'b1;
          lvl_q[k] = 1'b1;
          edge_q[k] = now_q + hi;
        end
        soft_q[k] = 1'b1;
        kick = kick && (count_tog() > 0);
        if (kick) begin
          last_dly_q = 2;
          r.timer_restart = 1'b1;
          r.next_delay_us = 20'd2;
        end
        r.actual_freq_hz = f[FREQ_W-1:0];
      end else begin
        if (soft_q[k]) begin
          soft_q[k] = 1'b0;
          tog_q[k] = 1'b0;
          lvl_q[k] = 1'b0;
        end
        if (b.op == OP_LEVEL) lvl_q[k] = b.level;
      end
    end
    r.pin_levels = lvl_q;
    r.soft_mask = soft_q;
    return r;
  endfunction

  task automatic send_beat(in_beat_t b);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    results_due.push_back(pwm_predict(b));
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FREQ_W-1:0] val);
    in_valid_i <= 1'b0;
    wait (results_due.size() == 0);
    repeat (200) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MIN_FREQ) lim_min = val;
    else lim_max = val;
  endtask

  function automatic in_beat_t mk(op_e o, int unsigned pin, int unsigned f,
                                  int unsigned d, bit l);
    in_beat_t b;
    b.op = o;
    b.pin_index = pin[PIN_W-1:0];
    b.freq_hz = f[INFREQ_W-1:0];
    b.duty_percent = d[DUTY_W-1:0];
    b.level = l;
    return b;
  endfunction

  task automatic test_directed();
    send_beat(mk(OP_TICK, 0, 0, 0, 0));
    send_beat(mk(OP_START, 0, 1000, 50, 0));
    send_beat(mk(OP_TICK, 31, 0, 0, 1));
    send_beat(mk(OP_START, 23, 1048575, 127, 1));
    send_beat(mk(OP_START, 1, 0, 0, 0));
    send_beat(mk(OP_START, 2, 5000, 100, 0));
    send_beat(mk(OP_START, 3, 9000, 1, 0));
    send_beat(mk(OP_START, 24, 100, 50, 0));
    send_beat(mk(OP_STOP, 31, 0, 0, 0));
    send_beat(mk(OP_LEVEL, 30, 0, 0, 1));
    send_beat(mk(OP_STOP, 5, 0, 0, 0));
    repeat (4) send_beat(mk(OP_TICK, 0, 0, 0, 0));
    send_beat(mk(OP_LEVEL, 0, 0, 0, 1));
    send_beat(mk(OP_LEVEL, 6, 0, 0, 1));
    send_beat(mk(OP_STOP, 3, 0, 0, 0));
    send_beat(mk(OP_TICK, 0, 0, 0, 0));
  endtask

  task automatic test_limits();
    write_reg(REG_MAX_FREQ, 19'd500000);
    write_reg(REG_MIN_FREQ, 19'd0);
    send_beat(mk(OP_START, 7, 0, 60, 0));
    send_beat(mk(OP_START, 8, 1000000, 50, 0));
    send_beat(mk(OP_START, 9, 400000, 99, 0));
    repeat (3) send_beat(mk(OP_TICK, 0, 0, 0, 0));
    write_reg(REG_MIN_FREQ, 19'd524287);
    write_reg(REG_MAX_FREQ, 19'd1);
    send_beat(mk(OP_START, 10, 3, 50, 0));
    send_beat(mk(OP_START, 11, 700000, 50, 0));
    send_beat(mk(OP_TICK, 0, 0, 0, 0));
  endtask

  task automatic random_run(int unsigned n);
    in_beat_t b;
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      b = in_beat_t'(IN_BITS'({$urandom, $urandom}));
      if (r < 40) b.op = OP_TICK;
      else if (r < 70) b.op = OP_START;
      else if (r < 85) b.op = OP_STOP;
      else b.op = OP_LEVEL;
      if ($urandom_range(0, 9) != 0) b.pin_index = PIN_W'($urandom_range(0, NPINS - 1));
      if ($urandom_range(0, 3) != 0) b.freq_hz = INFREQ_W'($urandom_range(1, 20000));
      if ($urandom_range(0, 3) != 0) b.duty_percent = DUTY_W'($urandom_range(1, 99));
      send_beat(b);
    end
  endtask

  task automatic test_random();
    write_reg(REG_MIN_FREQ, 19'd1);
    write_reg(REG_MAX_FREQ, 19'd10000);
    random_run(180);
    write_reg(REG_MIN_FREQ, 19'd50);
    write_reg(REG_MAX_FREQ, 19'd500000);
    random_run(180);
    write_reg(REG_MIN_FREQ, FREQ_W'($urandom_range(1, 2000)));
    write_reg(REG_MAX_FREQ, FREQ_W'($urandom_range(2000, 200000)));
    random_run(170);
  endtask

  always @(posedge clk_i) begin
    if (!rand_out_stall) out_stall_i <= 1'b0;
    else if ($urandom_range(0, 99) < 8) out_stall_i <= ($urandom_range(0, 2) == 0);
  end

  always @(posedge clk_i) begin
    out_beat_t x;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_seen++;
      if (results_due.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        x = results_due.pop_front();
        if (x.pin_levels !== out_beat_o.pin_levels) begin
          $error("pin_levels exp %h got %h", x.pin_levels, out_beat_o.pin_levels);
          errors++;
        end
        if (x.soft_mask !== out_beat_o.soft_mask) begin
          $error("soft_mask exp %h got %h", x.soft_mask, out_beat_o.soft_mask);
          errors++;
        end
        if (x.actual_freq_hz !== out_beat_o.actual_freq_hz) begin
          $error("actual_freq_hz exp %0d got %0d", x.actual_freq_hz,
                 out_beat_o.actual_freq_hz);
          errors++;
        end
        if (x.timer_restart !== out_beat_o.timer_restart) begin
          $error("timer_restart exp %0d got %0d", x.timer_restart,
                 out_beat_o.timer_restart);
          errors++;
        end
        if (x.next_delay_us !== out_beat_o.next_delay_us) begin
          $error("next_delay_us exp %0d got %0d", x.next_delay_us,
                 out_beat_o.next_delay_us);
          errors++;
        end
      end
    end
  end

  initial begin
    lim_min = 1;
    lim_max = 10000;
    soft_q = '0;
    tog_q = '0;
    lvl_q = '0;
    for (int i = 0; i < NPINS; i++) begin
      hi_q[i] = 0;
      lo_q[i] = 0;
      edge_q[i] = 0;
    end
    now_q = 0;
    last_dly_q = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    rand_out_stall = 1'b1;
    test_limits();
    test_random();
    in_valid_i <= 1'b0;
    wait (results_due.size() == 0);
    rand_out_stall = 1'b0;
    repeat (200) @(posedge clk_i);
    $display("covered %0d beats in, %0d results out: all ops, clamp extremes,", beats_sent,
             beats_seen);
    $display("static and toggling pins, late resyncs and out-of-range pins");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
